// File: sv/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg: shared types and constants for the sorted list store
// Holds the store depth, the count width, the status codes and the link
// record that is passed from one storage cell to the next.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int CAPACITY = 16;
    // Width of the stored count; it must hold CAPACITY itself.
    localparam int CNT_W    = 5;
    localparam int DATA_W   = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef logic signed [DATA_W-1:0] entry_t;
    typedef logic [CNT_W-1:0]         count_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } cmd_t;

    // Link from a cell to its right-hand neighbor.
    typedef struct packed {
        logic lt;   // this cell holds a value below the new one
        logic hit;  // a matching entry was found in this cell or to its left
    } link_t;

endpackage

// File: sv/sli_cell.sv
// ----------------------------------------------------------------------------
// sli_cell: one storage cell of the sorted list
// Holds one entry. On insert it keeps its value, takes the new value or
// takes its left neighbor's value; on delete it keeps its value or takes
// its right neighbor's value.
// ----------------------------------------------------------------------------
module sli_cell (
    input  logic            aclk,
    input  logic            cmd,
    input  sli_pkg::entry_t value,
    input  logic            occupied,
    input  logic            upd_en,
    input  sli_pkg::entry_t left_val,
    input  sli_pkg::entry_t right_val,
    input  sli_pkg::link_t  link_in,
    output sli_pkg::link_t  link_out,
    output sli_pkg::entry_t entry,
    output sli_pkg::entry_t entry_next
);
    import sli_pkg::*;

    entry_t entry_reg;
    logic   lt;
    logic   match;

    assign lt    = occupied && (entry_reg < value);
    assign match = occupied && (entry_reg == value);

    assign link_out.lt  = lt;
    assign link_out.hit = link_in.hit || match;

    always_comb begin
        entry_next = entry_reg;
        if (upd_en) begin
            if (cmd == CMD_INSERT) begin
                if (!lt) begin
                    entry_next = link_in.lt ? value : left_val;
                end
            end else begin
                if (link_in.hit || match) begin
                    entry_next = right_val;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: sv/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete: sorted store of signed values, insert / delete
// The result is registered into the output register when the input transaction is accepted.
// Throughput: one command per cycle while the output register is empty or being read; the row of
// compare-and-shift cells updates the entries in the cycle a command that changes the store is accepted.
// Reset (aresetn low, synchronous) empties the store and clears the output valid flag;
// entry contents are not cleared, the count alone marks them valid.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: [0] cmd, [32:1] value, [39:33] zero
    input  logic [sli_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata: [1:0] status, [6:2] entry_count, [38:7] smallest_value, [39] zero
    output logic [sli_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import sli_pkg::*;

    logic    cmd;
    entry_t  value;
    logic    accept;
    count_t  count_reg, count_next;
    logic    full;
    logic    found;
    logic    upd_en;
    status_t status;

    logic    [CAPACITY-1:0] occ;
    entry_t  entries      [CAPACITY];
    entry_t  entries_next [CAPACITY];
    link_t   links        [CAPACITY+1];

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    assign cmd    = s_tdata[0];
    assign value  = s_tdata[DATA_W:1];
    assign accept = s_tvalid && s_tready;
    assign full   = (count_reg == count_t'(CAPACITY));
    assign found  = links[CAPACITY].hit;

    assign links[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t lv, rv;
        assign occ[i] = (count_reg > count_t'(i));
        if (i == 0) begin : g_first
            assign lv = value;
        end else begin : g_mid
            assign lv = entries[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign rv = entries[i];
        end else begin : g_inner
            assign rv = entries[i+1];
        end
        sli_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .value      (value),
            .occupied   (occ[i]),
            .upd_en     (upd_en),
            .left_val   (lv),
            .right_val  (rv),
            .link_in    (links[i]),
            .link_out   (links[i+1]),
            .entry      (entries[i]),
            .entry_next (entries_next[i])
        );
    end

    always_comb begin
        upd_en     = 1'b0;
        count_next = count_reg;
        status     = ST_DONE;
        if (cmd == CMD_INSERT) begin
            if (full) begin
                status = ST_FULL;
            end else begin
                upd_en     = accept;
                count_next = count_reg + count_t'(1);
            end
        end else begin
            if (found) begin
                upd_en     = accept;
                count_next = count_reg - count_t'(1);
            end else begin
                status = ST_NOT_FOUND;
            end
        end
    end

    assign s_tready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= {1'b0,
                             (count_next != '0) ? entries_next[0] : entry_t'(0),
                             count_next,
                             status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= count_t'(CAPACITY))
        else $error("stored count above capacity");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(count_reg))
        else $error("stored count changed without a transaction");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == ST_FULL) |-> (m_tdata[6:2] == count_t'(CAPACITY)))
        else $error("full status with count below capacity");

    a_empty_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[6:2] == '0) |-> (m_tdata[38:7] == '0))
        else $error("empty store reports nonzero minimum");

endmodule

// File: verif/sorted_list_checker.sv
// ----------------------------------------------------------------------------
// sorted_list_checker: result checker for the sorted list store
// Watches both stream channels, keeps its own sorted copy of the store,
// predicts one reply per accepted command and compares every reply field.
// ----------------------------------------------------------------------------
module sorted_list_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // tdata: [0] cmd, [32:1] value, [39:33] zero
    input  logic [sli_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: [1:0] status, [6:2] entry_count, [38:7] smallest_value, [39] zero
    input  logic [sli_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output int                               fail_count,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sli_pkg::*;

    typedef struct {
        status_t status;
        count_t  count;
        entry_t  smallest;
    } reply_t;

    entry_t list_vals [CAPACITY];
    int     list_len;
    reply_t queued_replies [$];
    int     errs;

    assign fail_count = errs;

    // Applies one command to the local copy of the store and returns the reply.
    function automatic reply_t apply_list_cmd(cmd_t op, entry_t v);
        reply_t r;
        int     pos;
        pos = 0;
        r.status = ST_DONE;
        if (op == CMD_INSERT) begin
            if (list_len >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                while (pos < list_len && list_vals[pos] < v)
                    pos++;
                for (int i = list_len; i > pos; i--)
                    list_vals[i] = list_vals[i-1];
                list_vals[pos] = v;
                list_len++;
            end
        end else begin
            while (pos < list_len && list_vals[pos] != v)
                pos++;
            if (pos >= list_len) begin
                r.status = ST_NOT_FOUND;
            end else begin
                for (int i = pos; i + 1 < list_len; i++)
                    list_vals[i] = list_vals[i+1];
                list_len--;
            end
        end
        r.count    = count_t'(list_len);
        r.smallest = (list_len > 0) ? list_vals[0] : '0;
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (!aresetn) begin
            list_len = 0;
            queued_replies.delete();
            errs = 0;
        end else begin
            // The reply is registered after the command is accepted, so a reply
            // seen here never belongs to a command accepted at this same edge.
            if (m_tvalid && m_tready) begin
                got.status   = status_t'(m_tdata[1:0]);
                got.count    = m_tdata[6:2];
                got.smallest = m_tdata[38:7];
                if (queued_replies.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: reply with none pending: status %0d count %0d min %0d",
                                 $realtime, got.status, got.count, got.smallest);
                end else begin
                    want = queued_replies.pop_front();
                    if (got.status !== want.status || got.count !== want.count ||
                        got.smallest !== want.smallest) begin
                        errs++;
                        // Fields are listed as status/count/min.
                        if (errs <= 10)
                            $display("%0t: mismatch, expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, want.status, want.count, want.smallest,
                                     got.status, got.count, got.smallest);
                    end
                end
            end
            if (s_tvalid && s_tready)
                queued_replies.push_back(apply_list_cmd(cmd_t'(s_tdata[0]), s_tdata[32:1]));
        end
        pending = queued_replies.size();
    end

endmodule

// File: verif/sorted_list_insert_delete_tb.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_tb: testbench for the sorted list store
// Drives insert and delete commands in bursts, directed corner cases first,
// then random traffic that fills and drains the store, under receiver stalls.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sli_pkg::*;

    localparam int RANDOM_CMDS = 450;
    localparam int MAX_CYCLES  = 200000;
    localparam int HOLD_START  = 400;
    localparam int HOLD_LEN    = 300;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    int                      fail_count;
    int                      pending;
    int                      cycle_count = 0;
    int                      rx_cycle = 0;

    sorted_list_insert_delete dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sorted_list_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: a long hold-off once so the block backs up, otherwise a
    // rotating mix of always ready, random stalls and a fixed duty pattern.
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
            m_tready <= 1'b0;
        else begin
            case ((rx_cycle / 250) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ((rx_cycle % 5) < 2);
            endcase
        end
    end

    // Offers one command and holds it until the transaction completes.
    task automatic send_cmd(cmd_t op, entry_t v);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, v, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic entry_t pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return entry_t'($urandom_range(0, 10)) - 5;
        else if (r < 62)
            return 32'sh8000_0000;
        else if (r < 69)
            return 32'sh7fff_ffff;
        else
            return entry_t'($urandom);
    endfunction

    initial begin
        int   sent;
        int   burst;
        int   gap;
        int   ins_pct;
        cmd_t op;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty delete, extremes, duplicates, absent value, full store.
        send_cmd(CMD_DELETE, 32'sd4);
        send_cmd(CMD_INSERT, 32'sh7fff_ffff);
        send_cmd(CMD_INSERT, 32'sd0);
        send_cmd(CMD_INSERT, 32'sd0);
        send_cmd(CMD_DELETE, 32'sd0);
        send_cmd(CMD_DELETE, 32'sd7);
        for (int k = 0; k < 13; k++)
            send_cmd(CMD_INSERT, 32'sd100 - 50 * k);
        send_cmd(CMD_INSERT, 32'sh8000_0000);
        send_cmd(CMD_INSERT, 32'sd3);
        send_cmd(CMD_DELETE, 32'sh8000_0000);
        send_cmd(CMD_DELETE, 32'sh7fff_ffff);
        send_cmd(CMD_DELETE, 32'sd0);

        // Random: phases lean toward inserts or deletes so the store keeps
        // swinging between full and empty.
        sent = 0;
        while (sent < RANDOM_CMDS) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && sent < RANDOM_CMDS; b++) begin
                case ((sent / 40) % 3)
                    0: ins_pct = 80;
                    1: ins_pct = 25;
                    default: ins_pct = 50;
                endcase
                op = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
                send_cmd(op, pick_value());
                sent++;
            end
            // About a third of the bursts run straight into the next one.
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
sv/sli_pkg.sv
sv/sli_cell.sv
sv/sorted_list_insert_delete.sv
verif/sorted_list_checker.sv
verif/sorted_list_insert_delete_tb.sv
